// ----- sv/ffa_pkg.sv -----
// Shared types, constants and codes of the first-fit arena allocator.
`timescale 1ns / 1ps
package ffa_pkg;

  localparam int POOL_BYTES   = 65536;
  localparam int FREE_SLOTS   = 16;
  localparam int HEADER_BYTES = 24;

  localparam int REQ_W   = 17;
  localparam int ADDR_W  = 32;
  localparam int OFF_W   = $clog2(POOL_BYTES);
  localparam int GRAN_W  = OFF_W - 3;
  localparam int GRANULES = POOL_BYTES / 8;
  localparam int SIZE_W  = $clog2(POOL_BYTES + 1);
  localparam int TOT_W   = $clog2((2 ** REQ_W) + HEADER_BYTES + 7);
  localparam int BIG_W   = ((TOT_W > SIZE_W) ? TOT_W : SIZE_W) + 1;
  localparam int USE_W   = (SIZE_W > 17) ? SIZE_W : 17;
  localparam int IDX_W   = (FREE_SLOTS > 1) ? $clog2(FREE_SLOTS) : 1;
  localparam int CNT_W   = $clog2(FREE_SLOTS + 1);
  localparam int CMP_W   = (CNT_W > 5) ? CNT_W : 5;
  localparam int MARK_W  = 1 + SIZE_W;

  localparam int IN_DATA_W  = 56;
  localparam int OUT_DATA_W = 40;

  typedef enum logic [1:0] {
    REG_POOL_BASE    = 2'd0,
    REG_USABLE_BYTES = 2'd1,
    REG_FREE_LIMIT   = 2'd2,
    REG_NONE         = 2'd3
  } reg_e;

  typedef enum logic [1:0] {
    KIND_ALLOC  = 2'd0,
    KIND_FREE   = 2'd1,
    KIND_RESET  = 2'd2,
    KIND_UNUSED = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_ZERO_SIZE = 3'd1,
    ST_NO_MEM    = 3'd2,
    ST_NULL      = 3'd3,
    ST_BAD_HDR   = 3'd4,
    ST_LIST_FULL = 3'd5
  } status_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_ALLOC,
    S_FREE_CHK
  } state_e;

  typedef struct packed {
    logic              vld;
    logic [TOT_W-1:0]  total;
    logic              found;
    logic [IDX_W-1:0]  idx;
    logic [OFF_W-1:0]  off;
    logic [OFF_W-1:0]  last_off;
    logic [SIZE_W-1:0] last_size;
  } tok_t;

  typedef struct packed {
    logic              en;
    logic [IDX_W-1:0]  idx;
    logic [OFF_W-1:0]  off;
    logic [SIZE_W-1:0] size;
  } cell_wr_t;

endpackage

// ----- sv/first_fit_arena_allocator.sv -----
// Top level of the first-fit arena allocator: sequencer, mark memory, cell row.
// An allocate waits for the search token to walk the cell row, a free that passes the null
// and header range checks waits for the registered read of the header-mark memory, and
// every other request (zero-size allocate included) is answered directly. One request
// is in flight; the next is accepted from the cycle its result is taken.
// Reset: asynchronous active-low; afterwards a clearing pass writes all POOL_BYTES/8
// entries of the mark memory before the first request is accepted.
`timescale 1ns / 1ps
module first_fit_arena_allocator (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // request_bytes [16:0], pointer_address [48:17], zero pad
  input  logic [ffa_pkg::IN_DATA_W-1:0] s_axis_tdata,
  // kind [1:0]
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // user_address [31:0], status [34:32], zero pad
  output logic [ffa_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
  import ffa_pkg::*;

  logic [31:0] pool_base_q;
  logic [16:0] usable_q;
  logic [4:0]  free_limit_q;

  state_e state_q, state_d;
  logic [GRAN_W-1:0] clr_q;
  logic [SIZE_W-1:0] used_q, used_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [ADDR_W-1:0] ptr_q;
  logic [OFF_W-1:0]  off_q;
  tok_t              scan_q;

  logic              out_vld_q;
  logic [ADDR_W-1:0] out_addr_q, out_addr_d;
  status_e           out_stat_q, out_stat_d;
  logic              out_we;

  logic [MARK_W-1:0] mark_mem [GRANULES];
  logic [MARK_W-1:0] rd_q;
  logic [GRAN_W-1:0] rd_addr, wr_addr;
  logic [MARK_W-1:0] wr_data;
  logic              mem_we;

  tok_t     tok [FREE_SLOTS+1];
  tok_t     tok_in;
  cell_wr_t cw;

  kind_e             kind;
  logic [REQ_W-1:0]  req;
  logic [ADDR_W-1:0] ptr;
  logic              acc;
  logic              out_free;
  logic [TOT_W-1:0]  total_c;
  logic [ADDR_W-1:0] foff;
  logic              hdr_ok;
  logic [USE_W-1:0]  usable_ext;
  logic [SIZE_W-1:0] lim_b;
  logic [BIG_W-1:0]  bump_sum;
  logic [CMP_W-1:0]  lim_f;
  logic [BIG_W-1:0]  scan_tot;

  assign kind = kind_e'(s_axis_tuser);
  assign req  = s_axis_tdata[REQ_W-1:0];
  assign ptr  = s_axis_tdata[REQ_W+ADDR_W-1:REQ_W];

  assign out_free      = !out_vld_q || m_axis_tready;
  assign s_axis_tready = (state_q == S_IDLE) && out_free;
  assign acc           = s_axis_tvalid && s_axis_tready;

  assign total_c = (TOT_W'(req) + TOT_W'(HEADER_BYTES + 7)) & ~TOT_W'(7);
  assign foff    = ptr - ADDR_W'(HEADER_BYTES) - pool_base_q;
  assign hdr_ok  = (foff[2:0] == 3'd0) && (foff < ADDR_W'(POOL_BYTES));
  assign rd_addr = foff[OFF_W-1:3];

  assign usable_ext = USE_W'(usable_q);
  assign lim_b      = (usable_ext > USE_W'(POOL_BYTES)) ? SIZE_W'(POOL_BYTES)
                                                       : usable_ext[SIZE_W-1:0];
  assign scan_tot   = BIG_W'(scan_q.total);
  assign bump_sum   = BIG_W'(used_q) + scan_tot;
  assign lim_f      = (CMP_W'(free_limit_q) > CMP_W'(FREE_SLOTS)) ? CMP_W'(FREE_SLOTS)
                                                                 : CMP_W'(free_limit_q);

  always_comb begin
    tok_in       = '0;
    tok_in.vld   = acc && (kind == KIND_ALLOC) && (req != '0);
    tok_in.total = total_c;
  end

  assign tok[0] = tok_in;

  for (genvar i = 0; i < FREE_SLOTS; i++) begin : g_cell
    ffa_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cell_idx_i (CNT_W'(i)),
      .cnt_i      (cnt_q),
      .wr_i       (cw),
      .tok_i      (tok[i]),
      .tok_o      (tok[i+1])
    );
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLEAR: begin
        if (clr_q == GRAN_W'(GRANULES - 1)) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (acc) begin
          if (kind == KIND_ALLOC && req != '0) state_d = S_SCAN;
          else if (kind == KIND_FREE && ptr != '0 && hdr_ok) state_d = S_FREE_CHK;
        end
      end
      S_SCAN: begin
        if (tok[FREE_SLOTS].vld) state_d = S_ALLOC;
      end
      S_ALLOC:    state_d = S_IDLE;
      S_FREE_CHK: state_d = S_IDLE;
      default:    state_d = S_IDLE;
    endcase
  end

  always_comb begin
    used_d     = used_q;
    cnt_d      = cnt_q;
    out_we     = 1'b0;
    out_addr_d = '0;
    out_stat_d = ST_OK;
    mem_we     = 1'b0;
    wr_addr    = clr_q;
    wr_data    = '0;
    cw         = '0;
    unique case (state_q)
      S_CLEAR: begin
        mem_we = 1'b1;
      end
      S_IDLE: begin
        if (acc) begin
          unique case (kind)
            KIND_ALLOC: begin
              if (req == '0) begin
                out_we     = 1'b1;
                out_stat_d = ST_ZERO_SIZE;
              end
            end
            KIND_FREE: begin
              if (ptr == '0) begin
                out_we     = 1'b1;
                out_stat_d = ST_NULL;
              end else if (!hdr_ok) begin
                out_we     = 1'b1;
                out_stat_d = ST_BAD_HDR;
              end
            end
            KIND_RESET: begin
              used_d = '0;
              cnt_d  = '0;
              out_we = 1'b1;
            end
            KIND_UNUSED: begin
              out_we = 1'b1;
            end
            default: ;
          endcase
        end
      end
      S_SCAN: ;
      S_ALLOC: begin
        out_we = 1'b1;
        if (scan_q.found) begin
          cw.en      = 1'b1;
          cw.idx     = scan_q.idx;
          cw.off     = scan_q.last_off;
          cw.size    = scan_q.last_size;
          cnt_d      = cnt_q - CNT_W'(1);
          mem_we     = 1'b1;
          wr_addr    = scan_q.off[OFF_W-1:3];
          wr_data    = {1'b1, scan_tot[SIZE_W-1:0]};
          out_addr_d = pool_base_q + ADDR_W'(scan_q.off) + ADDR_W'(HEADER_BYTES);
        end else if (bump_sum > BIG_W'(lim_b)) begin
          out_stat_d = ST_NO_MEM;
        end else begin
          used_d     = bump_sum[SIZE_W-1:0];
          mem_we     = 1'b1;
          wr_addr    = used_q[OFF_W-1:3];
          wr_data    = {1'b1, scan_tot[SIZE_W-1:0]};
          out_addr_d = pool_base_q + ADDR_W'(used_q) + ADDR_W'(HEADER_BYTES);
        end
      end
      S_FREE_CHK: begin
        out_we = 1'b1;
        if (!rd_q[MARK_W-1]) begin
          out_stat_d = ST_BAD_HDR;
        end else if (CMP_W'(cnt_q) >= lim_f) begin
          out_stat_d = ST_LIST_FULL;
        end else begin
          cw.en      = 1'b1;
          cw.idx     = cnt_q[IDX_W-1:0];
          cw.off     = off_q;
          cw.size    = rd_q[SIZE_W-1:0];
          cnt_d      = cnt_q + CNT_W'(1);
          out_addr_d = ptr_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLEAR;
      clr_q        <= '0;
      used_q       <= '0;
      cnt_q        <= '0;
      out_vld_q    <= 1'b0;
      pool_base_q  <= 32'd65536;
      usable_q     <= 17'd65536;
      free_limit_q <= 5'd16;
    end else begin
      state_q <= state_d;
      used_q  <= used_d;
      cnt_q   <= cnt_d;
      if (state_q == S_CLEAR) clr_q <= clr_q + GRAN_W'(1);
      if (out_we) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
      if (cfg_we_i) begin
        unique case (reg_e'(cfg_idx_i))
          REG_POOL_BASE:    pool_base_q  <= cfg_data_i;
          REG_USABLE_BYTES: usable_q     <= cfg_data_i[16:0];
          REG_FREE_LIMIT:   free_limit_q <= cfg_data_i[4:0];
          REG_NONE: ;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_we) begin
      out_addr_q <= out_addr_d;
      out_stat_q <= out_stat_d;
    end
    if (acc) begin
      ptr_q <= ptr;
      off_q <= foff[OFF_W-1:0];
    end
    if (state_q == S_SCAN && tok[FREE_SLOTS].vld) scan_q <= tok[FREE_SLOTS];
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mark_mem[wr_addr] <= wr_data;
    rd_q <= mark_mem[rd_addr];
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {5'd0, out_stat_q, out_addr_q};

  a_clear_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLEAR) |-> !s_axis_tready)
    else $error("request accepted during mark clearing");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    CNT_W'(cnt_q) <= CNT_W'(FREE_SLOTS))
    else $error("free-list count above slot count");

  a_tok_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tok[FREE_SLOTS].vld |-> (state_q == S_SCAN))
    else $error("search token left the row outside a scan");

  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    BIG_W'(used_q) <= BIG_W'(POOL_BYTES))
    else $error("bump pointer beyond pool");

endmodule

// ----- sv/ffa_cell.sv -----
// One free-list cell: holds one entry and passes the search token along.
`timescale 1ns / 1ps
module ffa_cell (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [ffa_pkg::CNT_W-1:0] cell_idx_i,
  input  logic [ffa_pkg::CNT_W-1:0] cnt_i,
  input  ffa_pkg::cell_wr_t     wr_i,
  input  ffa_pkg::tok_t         tok_i,
  output ffa_pkg::tok_t         tok_o
);
  import ffa_pkg::*;

  logic [OFF_W-1:0]  off_q;
  logic [SIZE_W-1:0] size_q;
  tok_t              tok_d, tok_q;
  logic              in_list;
  logic              is_last;
  logic              fits;

  assign in_list = cell_idx_i < cnt_i;
  assign is_last = ({1'b0, cell_idx_i} + (CNT_W + 1)'(1)) == {1'b0, cnt_i};
  assign fits    = BIG_W'(size_q) >= BIG_W'(tok_i.total);

  always_comb begin
    tok_d = tok_i;
    if (tok_i.vld && in_list) begin
      if (!tok_i.found && fits) begin
        tok_d.found = 1'b1;
        tok_d.idx   = cell_idx_i[IDX_W-1:0];
        tok_d.off   = off_q;
      end
      if (is_last) begin
        tok_d.last_off  = off_q;
        tok_d.last_size = size_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.en && (wr_i.idx == cell_idx_i[IDX_W-1:0])) begin
      off_q  <= wr_i.off;
      size_q <= wr_i.size;
    end
  end

  assign tok_o = tok_q;

endmodule
